// ===== hdl/ttw_pkg.sv =====
`default_nettype none

package ttw_pkg;

  // Write queue between the character decoder and the write port.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // Character codes.
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharOne     = 8'h31;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLbrack  = 8'h5B;
  localparam logic [7:0] CharRbrack  = 8'h5D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharTilde   = 8'h7E;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharPlus    = 8'h2B;

  // Tile numbers and layout.
  localparam logic [15:0] IconBase    = 16'h0180;
  localparam logic [15:0] BadgeBase   = 16'h0186;
  localparam logic [15:0] StarTop     = 16'h0024;
  localparam logic [15:0] StarBottom  = 16'h0009;
  localparam logic [15:0] TildeTile   = 16'h0192;
  localparam logic [15:0] LetterOfs   = 16'd20;
  localparam logic [3:0]  ZeroGlyph   = 4'd9;
  localparam logic [7:0]  ColWrapMin  = 8'd28;
  localparam logic [7:0]  RowWrapMax  = 8'd19;
  localparam logic [7:0]  CornerMin   = 8'd30;
  localparam logic [7:0]  NewlineRows = 8'd3;
  localparam logic [7:0]  LetterSpan  = 8'd25;
  localparam logic [7:0]  DigitSpan   = 8'd9;
  localparam logic [2:0]  EscSkip     = 3'd4;
  localparam logic [14:0] RowStride   = 15'd32;

  // One queued drawing job: one or two writes, the second one row below.
  typedef struct packed {
    logic [14:0] offset;
    logic [15:0] top;
    logic [15:0] bottom;
    logic        two;
  } ttw_entry_t;

  typedef struct packed {
    logic       neg;
    logic [9:0] mag;
  } ttw_num_t;

  typedef enum logic [1:0] {
    ScanSpace,
    ScanDigits,
    ScanDone
  } ttw_scan_e;

  function automatic logic ttw_is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // atoi-like parse of three bytes: white space, optional sign, digits.
  function automatic ttw_num_t ttw_parse3(input logic [7:0] d0, input logic [7:0] d1,
                                          input logic [7:0] d2);
    logic [7:0] bytes [3];
    ttw_scan_e  phase;
    ttw_num_t   res;
    logic [9:0] digit;
    bytes[0] = d0;
    bytes[1] = d1;
    bytes[2] = d2;
    phase    = ScanSpace;
    res      = '0;
    for (int i = 0; i < 3; i++) begin
      digit = {2'b00, bytes[i] - CharZero};
      case (phase)
        ScanSpace: begin
          if (bytes[i] inside {CharSpace, [CharTab:CharCr]}) begin
            phase = ScanSpace;
          end else if (bytes[i] == CharMinus || bytes[i] == CharPlus) begin
            res.neg = (bytes[i] == CharMinus);
            phase   = ScanDigits;
          end else if (ttw_is_digit(bytes[i])) begin
            res.mag = digit;
            phase   = ScanDigits;
          end else begin
            phase = ScanDone;
          end
        end
        ScanDigits: begin
          if (ttw_is_digit(bytes[i])) begin
            res.mag = (res.mag << 3) + (res.mag << 1) + digit;
          end else begin
            phase = ScanDone;
          end
        end
        default: phase = ScanDone;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/text_to_tilemap_writer.sv =====
`default_nettype none

// Channel | Direction | Handshake              | Word
// --------+-----------+------------------------+---------------------------------------
// in      | input     | in_valid_i/in_stall_o   | one text byte, lookahead, string start
// out     | output    | out_valid_o/out_stall_i | one tile-map write (offset, data, last)
//
// An input word is taken every cycle while the write queue has room; the
// decoder updates the cursor in the cycle of acceptance.
// Each write leaves through a single registered output port, one per cycle
// while out_stall_i is low, so a drawn character makes two writes and a tilde
// or small icon makes one. Skipped, idle and non-drawing words make none.
// Reset (rst_ni low, asynchronous) clears the cursor, the queue and the output.
// A stall on the output holds the current word; the queue then fills and
// in_stall_o rises once it is full.

module text_to_tilemap_writer (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [7:0]         character_i,
  input  wire  [7:0]         ahead_one_i,
  input  wire  [7:0]         ahead_two_i,
  input  wire  [7:0]         ahead_three_i,
  input  wire  [7:0]         ahead_four_i,
  input  wire                first_i,
  input  wire  [7:0]         start_col_i,
  input  wire  [7:0]         start_row_i,
  input  wire  [15:0]        tile_base_i,
  input  wire  [3:0]         palette_i,
  input  wire  [1:0]         screen_i,
  input  wire  [7:0]         count_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [14:0] offset_o,
  output logic [15:0]        tile_data_o,
  output logic               last_o
);
  import ttw_pkg::*;

  ttw_entry_t entry, head;
  logic       push, pop, head_valid, full, accept;

  // The front stalls only on a full queue, even for words that draw nothing.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Decoder: classifies the byte, tracks cursor, count and escape skips.
  ttw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .character_i   (character_i),
    .ahead_one_i   (ahead_one_i),
    .ahead_two_i   (ahead_two_i),
    .ahead_three_i (ahead_three_i),
    .ahead_four_i  (ahead_four_i),
    .first_i       (first_i),
    .start_col_i   (start_col_i),
    .start_row_i   (start_row_i),
    .tile_base_i   (tile_base_i),
    .palette_i     (palette_i),
    .screen_i      (screen_i),
    .count_i       (count_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  // Short queue of drawing jobs so decoder and write port stall separately.
  ttw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  // Write port: splits each job into its top and bottom writes.
  ttw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .offset_o     (offset_o),
    .tile_data_o  (tile_data_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/ttw_fifo.sv =====
`default_nettype none

module ttw_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ttw_pkg::ttw_entry_t  entry_i,
  input  wire                  pop_i,
  output ttw_pkg::ttw_entry_t  head_o,
  output logic                 valid_o,
  output logic                 full_o
);
  import ttw_pkg::*;

  ttw_entry_t       mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(FifoDepth));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("write queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("write queue popped while empty");

endmodule

`default_nettype wire

// ===== hdl/ttw_front.sv =====
`default_nettype none

module ttw_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire  [7:0]           character_i,
  input  wire  [7:0]           ahead_one_i,
  input  wire  [7:0]           ahead_two_i,
  input  wire  [7:0]           ahead_three_i,
  input  wire  [7:0]           ahead_four_i,
  input  wire                  first_i,
  input  wire  [7:0]           start_col_i,
  input  wire  [7:0]           start_row_i,
  input  wire  [15:0]          tile_base_i,
  input  wire  [3:0]           palette_i,
  input  wire  [1:0]           screen_i,
  input  wire  [7:0]           count_i,
  output logic                 push_o,
  output ttw_pkg::ttw_entry_t  entry_o
);
  import ttw_pkg::*;

  logic [7:0]  col_q, col_d, row_q, row_d, left_q, left_d;
  logic [2:0]  skip_q, skip_d;
  logic        running_q, running_d;
  logic [15:0] base_q, base_d;
  logic [3:0]  pal_q, pal_d;
  logic [1:0]  scr_q, scr_d;

  logic [7:0]  col_e, row_e, left_e, col_w, row_w, left_n;
  logic [2:0]  skip_e, skip_w;
  logic        run_e, run_n, skipping, proceed, icon, has_wr;
  logic [15:0] pal16, top, bottom;
  logic [7:0]  dig_off, dig_m1, up_off, lo_off;
  logic [4:0]  letter_k;
  logic [3:0]  badge;
  logic [14:0] cell_ofs;
  ttw_num_t    esc;

  assign dig_off = character_i - CharZero;
  assign dig_m1  = character_i - CharOne;
  assign up_off  = character_i - CharUpperA;
  assign lo_off  = character_i - CharLowerA;
  assign esc     = ttw_parse3(ahead_one_i, ahead_two_i, ahead_three_i);
  assign badge   = esc.mag[3:0] - 4'd6;

  always_comb begin
    col_e    = first_i ? start_col_i : col_q;
    row_e    = first_i ? start_row_i : row_q;
    left_e   = first_i ? count_i     : left_q;
    base_d   = first_i ? tile_base_i : base_q;
    pal_d    = first_i ? palette_i   : pal_q;
    scr_d    = first_i ? screen_i    : scr_q;
    skip_e   = first_i ? 3'd0        : skip_q;
    run_e    = first_i ? (count_i != 8'd0) : running_q;
    skipping = !first_i && running_q && (skip_q != 3'd0);
    proceed  = run_e && !skipping;
    pal16    = {pal_d, 12'h000};
    letter_k = (up_off <= LetterSpan) ? up_off[4:0] : lo_off[4:0];

    col_d     = col_e;
    row_d     = row_e;
    left_d    = left_e;
    skip_d    = skipping ? skip_q - 3'd1 : skip_e;
    running_d = run_e;
    col_w     = col_e;
    row_w     = row_e;
    skip_w    = skip_e;
    left_n    = left_e;
    run_n     = run_e;
    has_wr    = 1'b0;
    entry_o.two = 1'b0;
    icon      = 1'b0;
    top       = '0;
    bottom    = '0;

    if (proceed) begin
      if (dig_off <= DigitSpan) begin
        top         = pal16 + base_d
                      + {11'd0, (character_i == CharZero) ? ZeroGlyph : dig_m1[3:0], 1'b0};
        bottom      = top + 16'd1;
        has_wr      = 1'b1;
        entry_o.two = 1'b1;
      end else if (up_off <= LetterSpan || lo_off <= LetterSpan) begin
        top         = pal16 + base_d + {10'd0, letter_k, 1'b0} + LetterOfs;
        bottom      = top + 16'd1;
        has_wr      = 1'b1;
        entry_o.two = 1'b1;
      end else if (character_i == CharLbrack && ahead_four_i == CharRbrack) begin
        skip_w = EscSkip;
        if (!esc.neg || esc.mag == 10'd0) begin
          if (esc.mag <= 10'd5) begin
            // Small icons sit one row up and one column to the left.
            col_w  = col_e - 8'd1;
            icon   = 1'b1;
            top    = pal16 + IconBase + {13'd0, esc.mag[2:0]};
            has_wr = 1'b1;
          end else if (esc.mag <= 10'd12) begin
            top         = pal16 + BadgeBase + {11'd0, badge, 1'b0};
            bottom      = top + 16'd1;
            has_wr      = 1'b1;
            entry_o.two = 1'b1;
          end
        end
      end else if (character_i == CharSpace) begin
        has_wr      = 1'b1;
        entry_o.two = 1'b1;
      end else if (character_i == CharStar) begin
        top         = pal16 + StarTop;
        bottom      = pal16 + StarBottom;
        has_wr      = 1'b1;
        entry_o.two = 1'b1;
      end else if (character_i == CharTilde) begin
        top    = pal16 + TildeTile;
        has_wr = 1'b1;
      end else if (character_i == CharNewline) begin
        col_w = 8'd0;
        row_w = row_e + NewlineRows;
      end

      // Cursor advance: row wrap, stop at far corner or count end.
      left_n = left_e - 8'd1;
      run_n  = 1'b1;
      col_d  = col_w;
      row_d  = row_w;
      if (col_w > ColWrapMin && row_w <= RowWrapMax) begin
        col_d = 8'd0;
        row_d = row_w + 8'd1;
      end else if (col_w > CornerMin && row_w > CornerMin) begin
        run_n = 1'b0;
      end else begin
        col_d = col_w + 8'd1;
      end
      if (left_n == 8'd0) begin
        run_n = 1'b0;
      end
      left_d    = left_n;
      running_d = run_n;
      skip_d    = run_n ? skip_w : 3'd0;
    end

    cell_ofs = {3'd0, scr_d, 10'd0} + {2'd0, row_w, 5'd0} + {7'd0, col_w};
    entry_o.offset = icon ? cell_ofs - RowStride : cell_ofs;
    entry_o.top    = top;
    entry_o.bottom = bottom;
    push_o         = accept_i && has_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      skip_q    <= '0;
      running_q <= 1'b0;
      base_q    <= '0;
      pal_q     <= '0;
      scr_q     <= '0;
    end else if (accept_i) begin
      col_q     <= col_d;
      row_q     <= row_d;
      left_q    <= left_d;
      skip_q    <= skip_d;
      running_q <= running_d;
      base_q    <= base_d;
      pal_q     <= pal_d;
      scr_q     <= scr_d;
    end
  end

  a_skip_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != 3'd0 |-> running_q)
    else $error("pending skips while no string is running");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= EscSkip)
    else $error("skip count above escape length");

endmodule

`default_nettype wire

// ===== hdl/ttw_back.sv =====
`default_nettype none

module ttw_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ttw_pkg::ttw_entry_t  head_i,
  input  wire                  head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic signed [14:0]   offset_o,
  output logic [15:0]          tile_data_o,
  output logic                 last_o
);
  import ttw_pkg::*;

  logic        phase_q, phase_d;
  logic        valid_q, valid_d;
  logic [14:0] offset_q, offset_d;
  logic [15:0] data_q, data_d;
  logic        last_q, last_d;
  logic        load;

  always_comb begin
    load     = head_valid_i && (!valid_q || !out_stall_i);
    phase_d  = phase_q;
    valid_d  = valid_q && out_stall_i;
    offset_d = offset_q;
    data_d   = data_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d  = 1'b1;
      offset_d = phase_q ? head_i.offset + RowStride : head_i.offset;
      data_d   = phase_q ? head_i.bottom : head_i.top;
      last_d   = phase_q || !head_i.two;
      pop_o    = phase_q || !head_i.two;
      phase_d  = !(phase_q || !head_i.two);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      valid_q  <= 1'b0;
      offset_q <= '0;
      data_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      valid_q  <= valid_d;
      offset_q <= offset_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign offset_o    = $signed(offset_q);
  assign tile_data_o = data_q;
  assign last_o      = last_q;

  a_phase_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_valid_i)
    else $error("second write pending with an empty queue");

  a_top_then_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |-> phase_q)
    else $error("non-final word shown without its bottom write pending");

endmodule

`default_nettype wire
